// ===== hw/rtl/tone_to_pwm_period_compare_unit_assert.svh =====
// assertion macros used by the checker file
`ifndef TONE_TO_PWM_PERIOD_COMPARE_UNIT_ASSERT_SVH
`define TONE_TO_PWM_PERIOD_COMPARE_UNIT_ASSERT_SVH

// implication checked while out of reset
`define TTP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication checked while out of reset
`define TTP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// next-cycle implication that also holds across reset
`define TTP_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/ttp_pkg.sv =====
// shared constants, types and note table for the tone to pwm unit
`default_nettype none
package ttp_pkg;

   localparam int FREQ_W     = 20;
   localparam int DUTY_W     = 7;
   localparam int CLK_W      = 25;
   localparam int DIVSR_W    = 26;
   localparam int QUOT_W     = 20;
   localparam int PERIOD_W   = 16;
   localparam int PROD_W     = 24;
   localparam int RECIP_W    = 26;
   localparam int RCP_PROD_W = PROD_W + RECIP_W;
   localparam int RECIP_SH   = 32;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;

   localparam logic [CLK_W-1:0] CLK_12M = 25'd12000000;
   localparam logic [CLK_W-1:0] CLK_22M = 25'd22118400;
   localparam logic [7:0] PRESCALE = 8'd20;
   localparam logic [2:0] DIV_CODE = 3'd4;
   // ceil(2^32 / 100), exact for products below 2^32 / 400
   localparam logic [RECIP_W-1:0] RECIP_100 = 26'd42949673;

   localparam logic OP_FREQ = 1'b0;
   localparam logic OP_NOTE = 1'b1;
   localparam logic CLK_SEL_12M = 1'b0;

   typedef struct packed {
      logic             en;
      logic [DUTY_W-1:0] duty;
   } side_type;

   localparam logic [10:0] NOTE_TABLE [0:47] = '{
      11'd0,    11'd0,    11'd262,  11'd277,  11'd294,  11'd311,  11'd330,  11'd330,
      11'd349,  11'd370,  11'd392,  11'd415,  11'd440,  11'd464,  11'd494,  11'd494,
      11'd0,    11'd0,    11'd523,  11'd554,  11'd587,  11'd622,  11'd659,  11'd659,
      11'd698,  11'd740,  11'd784,  11'd831,  11'd880,  11'd932,  11'd988,  11'd988,
      11'd0,    11'd0,    11'd1046, 11'd1109, 11'd1175, 11'd1245, 11'd1318, 11'd1318,
      11'd1397, 11'd1480, 11'd1568, 11'd1661, 11'd1760, 11'd1865, 11'd1976, 11'd1976
   };

   function automatic logic [10:0] note_hz(input logic [1:0] oct, input logic [2:0] stp,
                                           input logic shp);
      logic [5:0] idx;
      idx = {oct, stp, shp};
      if (oct == 2'd3) begin
         return 11'd0;
      end
      return NOTE_TABLE[idx];
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ttp_div.sv =====
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module ttp_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic                          in_valid,
   input  wire logic [ttp_pkg::CLK_W-1:0]     in_dividend,
   input  wire logic [ttp_pkg::DIVSR_W-1:0]   in_divisor,
   input  wire ttp_pkg::side_type             in_side,
   output      logic                          out_valid,
   output      logic [ttp_pkg::QUOT_W-1:0]    out_quot,
   output      ttp_pkg::side_type             out_side
);
   import ttp_pkg::*;

   localparam int HI_W = CLK_W - QUOT_W;

   logic                 valid_ff [0:QUOT_W];
   logic [DIVSR_W-1:0]   rem_ff   [0:QUOT_W];
   logic [QUOT_W-1:0]    low_ff   [0:QUOT_W];
   logic [QUOT_W-1:0]    quot_ff  [0:QUOT_W];
   logic [DIVSR_W-1:0]   divsr_ff [0:QUOT_W];
   side_type             side_ff  [0:QUOT_W];

   // stage 0 holds the top dividend bits, which are below the divisor whenever the frequency is nonzero
   always_comb begin
      valid_ff[0] = in_valid;
      rem_ff[0]   = {{(DIVSR_W-HI_W){1'b0}}, in_dividend[CLK_W-1:QUOT_W]};
      low_ff[0]   = in_dividend[QUOT_W-1:0];
      quot_ff[0]  = '0;
      divsr_ff[0] = in_divisor;
      side_ff[0]  = in_side;
   end

   for (genvar i = 0; i < QUOT_W; i++) begin : g_stage
      logic [DIVSR_W:0]   trial_in;
      logic [DIVSR_W:0]   diff_in;
      logic               take_in;
      logic [DIVSR_W-1:0] rem_in;

      always_comb begin
         trial_in = {rem_ff[i], low_ff[i][QUOT_W-1-i]};
         diff_in  = trial_in - {1'b0, divsr_ff[i]};
         take_in  = trial_in >= {1'b0, divsr_ff[i]};
         rem_in   = take_in ? diff_in[DIVSR_W-1:0] : trial_in[DIVSR_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[i+1] <= valid_ff[i];
         end
         if (advance) begin
            rem_ff[i+1]   <= rem_in;
            low_ff[i+1]   <= low_ff[i];
            quot_ff[i+1]  <= {quot_ff[i][QUOT_W-2:0], take_in};
            divsr_ff[i+1] <= divsr_ff[i];
            side_ff[i+1]  <= side_ff[i];
         end
      end
   end

   assign out_valid = valid_ff[QUOT_W];
   assign out_quot  = quot_ff[QUOT_W];
   assign out_side  = side_ff[QUOT_W];

endmodule
`default_nettype wire

// ===== hw/rtl/tone_to_pwm_period_compare_unit.sv =====
// top level: tone to pwm period and compare calculation pipeline
// Usage:
//   req channel carries one tone request per transaction: tuser is the op
//   (0 frequency, 1 note), tdata the frequency, note and duty fields.
//   rsp channel returns exactly one result per request, in order.
//   csr_wr_en/csr_wr_data write clock_select (0 12 MHz, 1 22.1184 MHz);
//   write it only while no request is in flight.
// Pipeline: the input stage loads at the accepting edge, then 20 divider
//   stages (one quotient bit each, set by the width of clock / (42 * f)),
//   then period, duty product, reciprocal product and the output register.
// Throughput: one transaction per cycle, sustained while the output is not stalled.
// Stall: when rsp_tvalid is high and rsp_tready low, the whole pipeline
//   holds and req_tready drops; no data is lost or repeated.
// Reset: synchronous, clears all valid bits and sets clock_select to 0.
`default_nettype none
module tone_to_pwm_period_compare_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic                             csr_wr_data,
   input  wire logic                             req_tvalid,
   output      logic                             req_tready,
   // frequency_hz[19:0], octave[21:20], step[24:22], sharp[25], duty_percent[32:26]
   input  wire logic [ttp_pkg::REQ_DATA_W-1:0]   req_tdata,
   // op[0]
   input  wire logic                             req_tuser,
   output      logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   // output_enable[0], period_count[16:1], compare_count[32:17],
   // prescale_value[40:33], divider_select[43:41]
   output      logic [ttp_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import ttp_pkg::*;

   logic advance;
   logic clk_sel_ff;

   // input stage
   logic                s0_valid_ff;
   logic [CLK_W-1:0]    s0_clk_ff;
   logic [DIVSR_W-1:0]  s0_divsr_ff;
   side_type            s0_side_ff;
   logic [FREQ_W-1:0]   freq_in;
   logic [DIVSR_W-1:0]  divsr_in;

   // divider output
   logic                dv_valid;
   logic [QUOT_W-1:0]   dv_quot;
   side_type            dv_side;

   // period stage
   logic                sp_valid_ff;
   logic [PERIOD_W-1:0] sp_period_ff;
   side_type            sp_side_ff;
   logic [PERIOD_W-1:0] period_in;

   // product stage
   logic                sm_valid_ff;
   logic                sm_en_ff;
   logic [PERIOD_W-1:0] sm_period_ff;
   logic [PROD_W-1:0]   sm_prod_ff;
   logic [PROD_W-1:0]   prod_in;

   // reciprocal stage
   logic                sr_valid_ff;
   logic                sr_en_ff;
   logic [PERIOD_W-1:0] sr_period_ff;
   logic [RCP_PROD_W-1:0] sr_rcp_ff;

   // output register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;
   logic [RCP_PROD_W-RECIP_SH-1:0] pct_in;
   logic [PERIOD_W-1:0]   cmp_in;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         clk_sel_ff <= CLK_SEL_12M;
      end else if (csr_wr_en) begin
         clk_sel_ff <= csr_wr_data;
      end
   end

   always_comb begin
      if (req_tuser == OP_NOTE) begin
         freq_in = {{(FREQ_W-11){1'b0}},
                    note_hz(req_tdata[21:20], req_tdata[24:22], req_tdata[25])};
      end else begin
         freq_in = req_tdata[FREQ_W-1:0];
      end
      // f * 42, the prescale+1 and the factor of two folded into one divisor
      divsr_in = {1'b0, freq_in, 5'd0} + {3'd0, freq_in, 3'd0} + {5'd0, freq_in, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_tvalid;
      end
      if (advance) begin
         s0_clk_ff       <= (clk_sel_ff == CLK_SEL_12M) ? CLK_12M : CLK_22M;
         s0_divsr_ff     <= divsr_in;
         s0_side_ff.en   <= freq_in != '0;
         s0_side_ff.duty <= req_tdata[32:26];
      end
   end

   ttp_div u_div (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (s0_valid_ff),
      .in_dividend (s0_clk_ff),
      .in_divisor  (s0_divsr_ff),
      .in_side     (s0_side_ff),
      .out_valid   (dv_valid),
      .out_quot    (dv_quot),
      .out_side    (dv_side)
   );

   // period saturation: quotient of 0 or 1 gives 0, above 65536 clamps
   always_comb begin
      if (dv_quot == '0) begin
         period_in = '0;
      end else if (dv_quot > {{(QUOT_W-PERIOD_W-1){1'b0}}, 1'b1, {PERIOD_W{1'b0}}}) begin
         period_in = '1;
      end else begin
         period_in = PERIOD_W'(dv_quot - QUOT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_valid_ff <= 1'b0;
      end else if (advance) begin
         sp_valid_ff <= dv_valid;
      end
      if (advance) begin
         sp_period_ff <= period_in;
         sp_side_ff   <= dv_side;
      end
   end

   assign prod_in = ({8'd0, sp_period_ff} + 24'd1) * {17'd0, sp_side_ff.duty};

   always_ff @(posedge clock) begin
      if (reset) begin
         sm_valid_ff <= 1'b0;
      end else if (advance) begin
         sm_valid_ff <= sp_valid_ff;
      end
      if (advance) begin
         sm_en_ff     <= sp_side_ff.en;
         sm_period_ff <= sp_period_ff;
         sm_prod_ff   <= prod_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sr_valid_ff <= 1'b0;
      end else if (advance) begin
         sr_valid_ff <= sm_valid_ff;
      end
      if (advance) begin
         sr_en_ff     <= sm_en_ff;
         sr_period_ff <= sm_period_ff;
         sr_rcp_ff    <= {{RECIP_W{1'b0}}, sm_prod_ff} * {{PROD_W{1'b0}}, RECIP_100};
      end
   end

   // divide by 100 via the reciprocal, then minus one (zero wraps to all ones); disabled gives all zeros
   always_comb begin
      pct_in = sr_rcp_ff[RCP_PROD_W-1:RECIP_SH];
      cmp_in = PERIOD_W'(pct_in - 1'b1);
      if (sr_en_ff) begin
         rsp_data_in = {4'd0, DIV_CODE, PRESCALE, cmp_in, sr_period_ff, 1'b1};
      end else begin
         rsp_data_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= sr_valid_ff;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/ttp_checker.sv =====
// port-level checker for the tone to pwm unit and its bind
`default_nettype none
`include "tone_to_pwm_period_compare_unit_assert.svh"
module ttp_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [ttp_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import ttp_pkg::*;

   logic rsp_stall;
   logic fixed_ok;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign fixed_ok  = (rsp_tdata[40:33] == PRESCALE) && (rsp_tdata[43:41] == DIV_CODE);

   // a stalled result transaction holds its data
   `TTP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))
   // nothing leaves right after reset
   `TTP_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid)
   // disabled output carries all zero fields
   `TTP_ASSERT_IMPLY(a_off_zero, clock, reset, rsp_tvalid && !rsp_tdata[0], rsp_tdata == '0)
   // enabled output carries the fixed prescale and divider code
   `TTP_ASSERT_IMPLY(a_on_fixed, clock, reset, rsp_tvalid && rsp_tdata[0], fixed_ok)
   // a stalled output blocks new requests
   `TTP_ASSERT_IMPLY(a_stall_block, clock, reset, rsp_stall, !req_tready)

endmodule

bind tone_to_pwm_period_compare_unit ttp_checker u_ttp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

// ===== bench/tb_tone_to_pwm_period_compare_unit.sv =====
// testbench for the tone to pwm period and compare unit
`default_nettype none
module tb_tone_to_pwm_period_compare_unit;
   import ttp_pkg::*;

   localparam int N_RANDOM = 1700;
   localparam int LATENCY = 25;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic        op;
      logic [19:0] freq;
      logic [1:0]  oct;
      logic [2:0]  stp;
      logic        shp;
      logic [6:0]  duty;
   } tone_req_t;

   typedef struct packed {
      logic        en;
      logic [15:0] period;
      logic [15:0] cmp;
      logic [7:0]  pre;
      logic [2:0]  div;
   } pwm_setting_t;

   typedef struct {
      tone_req_t    req;
      logic         use_exp;
      pwm_setting_t exp;
   } stim_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic csr_wr_data = 1'b0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   pwm_setting_t expected_settings[$];
   logic clk_sel = CLK_SEL_12M;
   bit failed = 0;
   bit rsp_stall_on = 1'b1;
   longint cycle_count = 0;

   tone_to_pwm_period_compare_unit u_dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [10:0] lookup_note_hz(logic [1:0] o, logic [2:0] s, logic sh);
      logic [10:0] tbl [0:2][0:7][0:1];
      tbl = '{
         '{'{0,0},'{262,277},'{294,311},'{330,330},'{349,370},'{392,415},'{440,464},'{494,494}},
         '{'{0,0},'{523,554},'{587,622},'{659,659},'{698,740},'{784,831},'{880,932},'{988,988}},
         '{'{0,0},'{1046,1109},'{1175,1245},'{1318,1318},'{1397,1480},'{1568,1661},
           '{1760,1865},'{1976,1976}}};
      if (o == 2'd3) return 11'd0;
      return tbl[o][s][sh];
   endfunction

   function automatic pwm_setting_t compute_pwm(tone_req_t r, logic sel);
      pwm_setting_t s;
      int unsigned f, clk, q, per, c;
      f = (r.op == OP_NOTE) ? lookup_note_hz(r.oct, r.stp, r.shp) : r.freq;
      s = '0;
      if (f == 0) return s;
      clk = sel ? 22118400 : 12000000;
      q = clk / f / 21 / 2;
      if (q == 0) per = 0;
      else if (q - 1 > 65535) per = 65535;
      else per = q - 1;
      c = ((per + 1) * r.duty / 100 - 1) & 32'hFFFF;
      s.en = 1'b1;
      s.period = per[15:0];
      s.cmp = c[15:0];
      s.pre = 8'd20;
      s.div = 3'd4;
      return s;
   endfunction

   function automatic int unsigned gap_len();
      if ($urandom_range(0, 19) == 0) return $urandom_range(5, 40);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   task automatic send_tone(tone_req_t r, logic use_exp, pwm_setting_t exp);
      pwm_setting_t p;
      int unsigned g;
      p = compute_pwm(r, clk_sel);
      if (use_exp && p != exp) begin
         $display("%0t table row disagrees: expected %h actual %h", $time, exp, p);
         failed = 1;
      end
      expected_settings.push_back(use_exp ? exp : p);
      req_tdata <= {7'd0, r.duty, r.shp, r.stp, r.oct, r.freq};
      req_tuser <= r.op;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      g = gap_len();
      if (g != 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic drain_and_write(logic v);
      req_tvalid <= 1'b0;
      while (expected_settings.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      clk_sel = v;
   endtask

   function automatic tone_req_t rand_tone();
      tone_req_t r;
      r.op = $urandom_range(0, 1);
      case ($urandom_range(0, 5))
         0: r.freq = $urandom_range(0, 20);
         1: r.freq = $urandom_range(900000, 1048575);
         2: r.freq = $urandom;
         default: r.freq = $urandom_range(1, 3000);
      endcase
      r.oct = $urandom_range(0, 3);
      r.stp = $urandom_range(0, 7);
      r.shp = $urandom_range(0, 1);
      r.duty = ($urandom_range(0, 9) == 0) ? $urandom_range(101, 127) : $urandom_range(0, 100);
      return r;
   endfunction

   // rsp side: random backpressure while rsp_stall_on is set and the compare against the oldest expectation
   always @(posedge clock) begin
      pwm_setting_t got, want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.en     = rsp_tdata[0];
         got.period = rsp_tdata[16:1];
         got.cmp    = rsp_tdata[32:17];
         got.pre    = rsp_tdata[40:33];
         got.div    = rsp_tdata[43:41];
         if (expected_settings.size() == 0) begin
            $display("%0t unexpected transaction: actual %h", $time, got);
            failed = 1;
         end else begin
            want = expected_settings.pop_front();
            if (got.en !== want.en)
               $display("%0t enable: expected %h actual %h", $time, want.en, got.en);
            if (got.period !== want.period)
               $display("%0t period: expected %h actual %h", $time, want.period, got.period);
            if (got.cmp !== want.cmp)
               $display("%0t compare: expected %h actual %h", $time, want.cmp, got.cmp);
            if (got.pre !== want.pre)
               $display("%0t prescale: expected %h actual %h", $time, want.pre, got.pre);
            if (got.div !== want.div)
               $display("%0t divider: expected %h actual %h", $time, want.div, got.div);
            if (got !== want) failed = 1;
         end
      end
      rsp_tready <= rsp_stall_on ? ($urandom_range(0, 19) == 0 ? 1'b0 :
                                    $urandom_range(0, 3) != 0) : 1'b1;
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   stim_row_t directed[$];

   initial begin
      tone_req_t r;
      pwm_setting_t z;
      z = '0;
      // off, rest, bad octave, extremes; expected values only where obvious
      directed = '{
         '{'{OP_FREQ, 20'd0, 2'd0, 3'd0, 1'b0, 7'd50}, 1'b1, '0},
         '{'{OP_NOTE, 20'hFFFFF, 2'd1, 3'd0, 1'b1, 7'd50}, 1'b1, '0},
         '{'{OP_NOTE, 20'd0, 2'd3, 3'd7, 1'b1, 7'd127}, 1'b1, '0},
         '{'{OP_FREQ, 20'hFFFFF, 2'd3, 3'd7, 1'b1, 7'd0}, 1'b1,
           '{1'b1, 16'd0, 16'hFFFF, 8'd20, 3'd4}},
         '{'{OP_FREQ, 20'hFFFFF, 2'd0, 3'd0, 1'b0, 7'd100}, 1'b1,
           '{1'b1, 16'd0, 16'd0, 8'd20, 3'd4}},
         '{'{OP_FREQ, 20'd1, 2'd0, 3'd0, 1'b0, 7'd100}, 1'b1,
           '{1'b1, 16'hFFFF, 16'hFFFF, 8'd20, 3'd4}},
         '{'{OP_FREQ, 20'd1, 2'd0, 3'd0, 1'b0, 7'd0}, 1'b1,
           '{1'b1, 16'hFFFF, 16'hFFFF, 8'd20, 3'd4}},
         '{'{OP_FREQ, 20'd1, 2'd0, 3'd0, 1'b0, 7'd127}, 1'b0, '0},
         '{'{OP_FREQ, 20'd440, 2'd0, 3'd0, 1'b0, 7'd50}, 1'b0, '0},
         '{'{OP_FREQ, 20'd285714, 2'd0, 3'd0, 1'b0, 7'd100}, 1'b0, '0},
         '{'{OP_FREQ, 20'd142857, 2'd0, 3'd0, 1'b0, 7'd50}, 1'b0, '0},
         '{'{OP_NOTE, 20'd0, 2'd0, 3'd1, 1'b0, 7'd50}, 1'b0, '0},
         '{'{OP_NOTE, 20'd0, 2'd0, 3'd7, 1'b1, 7'd25}, 1'b0, '0},
         '{'{OP_NOTE, 20'd0, 2'd1, 3'd4, 1'b1, 7'd75}, 1'b0, '0},
         '{'{OP_NOTE, 20'd0, 2'd2, 3'd1, 1'b1, 7'd1}, 1'b0, '0},
         '{'{OP_NOTE, 20'd0, 2'd2, 3'd7, 1'b0, 7'd99}, 1'b0, '0},
         '{'{OP_NOTE, 20'd0, 2'd2, 3'd6, 1'b1, 7'd127}, 1'b0, '0}
      };
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) send_tone(directed[i].req, directed[i].use_exp, directed[i].exp);
      drain_and_write(1'b1);
      foreach (directed[i])
         if (i > 7) send_tone(directed[i].req, 1'b0, z);
      for (int ph = 0; ph < 4; ph++) begin
         drain_and_write(ph[0]);
         rsp_stall_on = (ph != 2);
         for (int k = 0; k < N_RANDOM / 4; k++) begin
            r = rand_tone();
            send_tone(r, 1'b0, z);
         end
      end
      req_tvalid <= 1'b0;
      while (expected_settings.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (!failed) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ttp_pkg.sv
hw/rtl/ttp_div.sv
hw/rtl/tone_to_pwm_period_compare_unit.sv
hw/rtl/ttp_checker.sv
bench/tb_tone_to_pwm_period_compare_unit.sv
